FILE: hdl/hysteresis_thermostat_compressor_ctrl_defines.svh
// Assertion macros shared by the thermostat controller checker.
// Depends on signals named clock and reset in the scope of each use.
`ifndef HYSTERESIS_THERMOSTAT_COMPRESSOR_CTRL_DEFINES_SVH
`define HYSTERESIS_THERMOSTAT_COMPRESSOR_CTRL_DEFINES_SVH

// Consequent checked in the same cycle, ignored while reset is high.
`define HTCC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the next cycle, ignored while reset is high.
`define HTCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Checked in the cycle after any reset cycle.
`define HTCC_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/htcc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the thermostat compressor controller.
// No dependencies; every other file but the assertion macros header imports it.
package htcc_pkg;

   localparam int TEMP_W       = 15;
   localparam int TARGET_W     = 11;
   localparam int HYST_W       = 9;
   localparam int MIN_OFF_W    = 16;
   localparam int COUNT_W      = 32;
   localparam int ACTION_W     = 3;
   localparam int STATUS_W     = 2;
   localparam int MODE_W       = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 4;

   localparam logic [TARGET_W-1:0]  TARGET_RESET  = TARGET_W'(400);
   localparam logic [TARGET_W-1:0]  TARGET_MAX    = TARGET_W'(1500);
   localparam logic [HYST_W-1:0]    HYST_RESET    = HYST_W'(100);
   localparam logic [HYST_W-1:0]    HYST_MIN      = HYST_W'(50);
   localparam logic [HYST_W-1:0]    HYST_MAX      = HYST_W'(300);
   localparam logic [MIN_OFF_W-1:0] MIN_OFF_RESET = MIN_OFF_W'(300);

   // A sample must move by more than this many hundredths to count as a change.
   localparam int CHANGE_LIMIT = 10;

   // Smoothing: floor((9*avg + sample + 5) / 10). The sum is biased by a
   // multiple of ten to a non-negative value, divided by a reciprocal
   // multiply, and the bias is removed by flipping the top quotient bit.
   localparam int SUM_W       = TEMP_W + 5;
   localparam int BIASED_W    = TEMP_W + 4;
   localparam int AVG_BIAS    = 10 * (1 << (TEMP_W - 1));
   localparam int DIV10_SHIFT = BIASED_W + 3;
   localparam int DIV10_MUL   = ((1 << DIV10_SHIFT) + 9) / 10;
   localparam int AVG_ROUND   = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK    = 3'd0,
      ACT_SAMPLE  = 3'd1,
      ACT_COMP    = 3'd2,
      ACT_FAN     = 3'd3,
      ACT_DEFROST = 3'd4
   } action_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_AUTO   = 2'd0,
      MODE_MANUAL = 2'd1,
      MODE_OFF    = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_REFUSED = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_SETPOINT    = 2'd0,
      REG_HYSTERESIS  = 2'd1,
      REG_OP_MODE     = 2'd2,
      REG_MIN_OFF     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [TARGET_W-1:0]  setpoint;
      logic [HYST_W-1:0]    hysteresis;
      mode_type             op_mode;
      logic [MIN_OFF_W-1:0] min_off_seconds;
      logic                 force_off;
   } cfg_type;

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
   endfunction

endpackage

FILE: hdl/htcc_req_if.sv
`timescale 1ns / 1ps
// Request channel of the thermostat controller: valid/ready plus one event.
// Depends on htcc_pkg for field widths.
interface htcc_req_if;
   import htcc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [TEMP_W-1:0]   temperature;
   logic                       switch_on;

   modport source (output valid, action, temperature, switch_on, input ready);
   modport sink   (input valid, action, temperature, switch_on, output ready);
endinterface

FILE: hdl/htcc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the thermostat controller: valid/ready plus relay and
// counter status. Depends on htcc_pkg for field widths.
interface htcc_rsp_if;
   import htcc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       compressor_on;
   logic                       fan_on;
   logic [STATUS_W-1:0]        status;
   logic                       temp_changed;
   logic signed [TEMP_W-1:0]   average_temp;
   logic signed [TEMP_W-1:0]   latest_temp;
   logic [COUNT_W-1:0]         start_count;
   logic [COUNT_W-1:0]         runtime_seconds;

   modport source (output valid, compressor_on, fan_on, status, temp_changed,
                   average_temp, latest_temp, start_count, runtime_seconds,
                   input ready);
   modport sink   (input valid, compressor_on, fan_on, status, temp_changed,
                   average_temp, latest_temp, start_count, runtime_seconds,
                   output ready);
endinterface

FILE: hdl/htcc_csr.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the thermostat controller.
// Depends on htcc_pkg; out-of-range writes leave a register unchanged.
module htcc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [htcc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [htcc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [htcc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output htcc_pkg::cfg_type                 cfg
);
   import htcc_pkg::*;

   logic [TARGET_W-1:0]  target_ff, target_in;
   logic [HYST_W-1:0]    hyst_ff, hyst_in;
   mode_type             mode_ff, mode_in;
   logic [MIN_OFF_W-1:0] min_off_ff, min_off_in;
   logic                 wr_en;
   logic                 force_off;
   reg_index_type        index;
   logic [TARGET_W-1:0]  wr_target;
   logic [HYST_W-1:0]    wr_hyst;
   logic [MODE_W-1:0]    wr_mode;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign index     = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_target = pwdata[TARGET_W-1:0];
   assign wr_hyst   = pwdata[HYST_W-1:0];
   assign wr_mode   = pwdata[MODE_W-1:0];

   always_comb begin
      target_in  = target_ff;
      hyst_in    = hyst_ff;
      mode_in    = mode_ff;
      min_off_in = min_off_ff;
      force_off  = 1'b0;
      if (wr_en) begin
         case (index)
            REG_SETPOINT: begin
               if (wr_target inside {[0:TARGET_MAX]}) target_in = wr_target;
            end
            REG_HYSTERESIS: begin
               if (wr_hyst inside {[HYST_MIN:HYST_MAX]}) hyst_in = wr_hyst;
            end
            REG_OP_MODE: begin
               if (wr_mode inside {MODE_AUTO, MODE_MANUAL, MODE_OFF}) begin
                  mode_in   = mode_type'(wr_mode);
                  force_off = (mode_type'(wr_mode) == MODE_OFF);
               end
            end
            REG_MIN_OFF: begin
               min_off_in = pwdata[MIN_OFF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= TARGET_RESET;
         hyst_ff    <= HYST_RESET;
         mode_ff    <= MODE_AUTO;
         min_off_ff <= MIN_OFF_RESET;
      end else begin
         target_ff  <= target_in;
         hyst_ff    <= hyst_in;
         mode_ff    <= mode_in;
         min_off_ff <= min_off_in;
      end
   end

   always_comb begin
      case (index)
         REG_SETPOINT:    prdata = CSR_DATA_W'(target_ff);
         REG_HYSTERESIS:  prdata = CSR_DATA_W'(hyst_ff);
         REG_OP_MODE:     prdata = CSR_DATA_W'(mode_ff);
         REG_MIN_OFF:     prdata = CSR_DATA_W'(min_off_ff);
         default:         prdata = '0;
      endcase
   end

   // The off-mode pulse lets the core stop both relays at the write itself.
   assign cfg.setpoint        = target_ff;
   assign cfg.hysteresis      = hyst_ff;
   assign cfg.op_mode         = mode_ff;
   assign cfg.min_off_seconds = min_off_ff;
   assign cfg.force_off       = force_off;

endmodule

FILE: hdl/htcc_core.sv
`timescale 1ns / 1ps
// Event processing of the thermostat controller: input register, relay and
// counter state, smoothing and the result register. Depends on htcc_pkg.
module htcc_core (
   input  logic              clock,
   input  logic              reset,
   input  htcc_pkg::cfg_type cfg,
   htcc_req_if.sink          req_if,
   htcc_rsp_if.source        rsp_if
);
   import htcc_pkg::*;

   // Input register.
   logic                     s1_valid_ff, s1_valid_in;
   logic [ACTION_W-1:0]      s1_action_ff;
   logic signed [TEMP_W-1:0] s1_temp_ff;
   logic                     s1_switch_ff;
   logic                     s1_go;
   logic                     req_take;

   // Controller state.
   logic                     comp_ff, comp_in;
   logic                     fan_ff, fan_in;
   logic                     stopped_ff, stopped_in;
   logic [COUNT_W-1:0]       idle_ff, idle_in;
   logic [COUNT_W-1:0]       run_ff, run_in;
   logic [COUNT_W-1:0]       total_ff, total_in;
   logic [COUNT_W-1:0]       starts_ff, starts_in;
   logic signed [TEMP_W-1:0] cur_temp_ff, cur_temp_in;
   logic signed [TEMP_W-1:0] avg_ff, avg_in;
   logic                     avg_valid_ff, avg_valid_in;

   // Result register.
   logic                     out_valid_ff, out_valid_in;
   logic                     out_comp_ff;
   logic                     out_fan_ff;
   status_type               out_status_ff;
   logic                     out_changed_ff;
   logic signed [TEMP_W-1:0] out_avg_ff;
   logic signed [TEMP_W-1:0] out_temp_ff;
   logic [COUNT_W-1:0]       out_starts_ff;
   logic [COUNT_W-1:0]       out_runtime_ff;

   status_type               status_v;
   logic                     changed_v;
   logic [COUNT_W-1:0]       runtime_v;

   logic signed [TEMP_W:0]   temp_diff;
   logic [TEMP_W:0]          temp_dist;
   logic signed [SUM_W-1:0]  avg_sum;
   logic [SUM_W-1:0]         avg_biased;
   logic [2*BIASED_W-1:0]    avg_prod;
   logic [TEMP_W-1:0]        avg_quot;
   logic signed [TEMP_W-1:0] avg_next;
   logic signed [TEMP_W:0]   target_s;
   logic signed [TEMP_W:0]   restart_s;
   logic                     off_time_ok;

   assign s1_go         = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !reset && (!s1_valid_ff || s1_go);
   assign req_take      = req_if.valid && req_if.ready;
   assign s1_valid_in   = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign out_valid_in  = s1_go ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   // Change detection on the sample against the last one.
   assign temp_diff = {cur_temp_ff[TEMP_W-1], cur_temp_ff} - {s1_temp_ff[TEMP_W-1], s1_temp_ff};
   assign temp_dist = temp_diff[TEMP_W] ? (TEMP_W+1)'(-temp_diff) : temp_diff;

   // Smoothing step, worked on the stored average and the registered sample.
   always_comb begin
      avg_sum    = (SUM_W'(avg_ff) <<< 3) + SUM_W'(avg_ff) + SUM_W'(s1_temp_ff)
                   + SUM_W'(AVG_ROUND);
      avg_biased = avg_sum + SUM_W'(AVG_BIAS);
      avg_prod   = avg_biased[BIASED_W-1:0] * BIASED_W'(DIV10_MUL);
      avg_quot   = avg_prod[DIV10_SHIFT +: TEMP_W];
      avg_next   = {~avg_quot[TEMP_W-1], avg_quot[TEMP_W-2:0]};
   end

   assign target_s  = (TEMP_W+1)'(cfg.setpoint);
   assign restart_s = (TEMP_W+1)'(cfg.setpoint) + (TEMP_W+1)'(cfg.hysteresis);

   always_comb begin
      comp_in      = comp_ff;
      fan_in       = fan_ff;
      stopped_in   = stopped_ff;
      idle_in      = idle_ff;
      run_in       = run_ff;
      total_in     = total_ff;
      starts_in    = starts_ff;
      cur_temp_in  = cur_temp_ff;
      avg_in       = avg_ff;
      avg_valid_in = avg_valid_ff;
      status_v     = STATUS_DONE;
      changed_v    = 1'b0;
      off_time_ok  = 1'b1;

      // Off mode stops both relays, at the mode write and before every request.
      if (cfg.force_off || (s1_go && cfg.op_mode == MODE_OFF)) begin
         if (comp_in) begin
            comp_in    = 1'b0;
            total_in   = sat_add(total_in, run_in);
            run_in     = '0;
            idle_in    = '0;
            stopped_in = 1'b1;
         end
         fan_in = 1'b0;
      end

      if (s1_go) begin
         off_time_ok = !stopped_in || (idle_in >= COUNT_W'(cfg.min_off_seconds));
         case (action_type'(s1_action_ff))
            ACT_TICK: begin
               if (comp_in) begin
                  run_in = sat_add(run_in, COUNT_W'(1));
               end else if (stopped_in) begin
                  idle_in = sat_add(idle_in, COUNT_W'(1));
               end
               off_time_ok = !stopped_in || (idle_in >= COUNT_W'(cfg.min_off_seconds));
               if (cfg.op_mode == MODE_AUTO) begin
                  if (comp_in) begin
                     if ((TEMP_W+1)'(cur_temp_ff) <= target_s) begin
                        comp_in    = 1'b0;
                        total_in   = sat_add(total_in, run_in);
                        run_in     = '0;
                        idle_in    = '0;
                        stopped_in = 1'b1;
                     end
                  end else if ((TEMP_W+1)'(cur_temp_ff) >= restart_s) begin
                     if (!off_time_ok) begin
                        status_v = STATUS_REFUSED;
                     end else begin
                        comp_in   = 1'b1;
                        run_in    = '0;
                        starts_in = sat_add(starts_in, COUNT_W'(1));
                        fan_in    = 1'b1;
                     end
                  end
               end
            end
            ACT_SAMPLE: begin
               cur_temp_in = s1_temp_ff;
               if (temp_dist > (TEMP_W+1)'(CHANGE_LIMIT)) begin
                  changed_v = 1'b1;
                  if (!avg_valid_ff) begin
                     avg_in       = s1_temp_ff;
                     avg_valid_in = 1'b1;
                  end else begin
                     avg_in = avg_next;
                  end
               end
            end
            ACT_COMP: begin
               if (cfg.op_mode != MODE_MANUAL) begin
                  status_v = STATUS_IGNORED;
               end else if (s1_switch_ff) begin
                  if (!comp_in) begin
                     if (!off_time_ok) begin
                        status_v = STATUS_REFUSED;
                     end else begin
                        comp_in   = 1'b1;
                        run_in    = '0;
                        starts_in = sat_add(starts_in, COUNT_W'(1));
                     end
                  end
               end else if (comp_in) begin
                  comp_in    = 1'b0;
                  total_in   = sat_add(total_in, run_in);
                  run_in     = '0;
                  idle_in    = '0;
                  stopped_in = 1'b1;
               end
            end
            ACT_FAN: begin
               if (cfg.op_mode != MODE_MANUAL) begin
                  status_v = STATUS_IGNORED;
               end else begin
                  fan_in = s1_switch_ff;
               end
            end
            ACT_DEFROST: begin
               if (comp_in) begin
                  comp_in    = 1'b0;
                  total_in   = sat_add(total_in, run_in);
                  run_in     = '0;
                  idle_in    = '0;
                  stopped_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      runtime_v = sat_add(total_in, run_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         comp_ff      <= 1'b0;
         fan_ff       <= 1'b0;
         stopped_ff   <= 1'b0;
         idle_ff      <= '0;
         run_ff       <= '0;
         total_ff     <= '0;
         starts_ff    <= '0;
         cur_temp_ff  <= '0;
         avg_ff       <= '0;
         avg_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         comp_ff      <= comp_in;
         fan_ff       <= fan_in;
         stopped_ff   <= stopped_in;
         idle_ff      <= idle_in;
         run_ff       <= run_in;
         total_ff     <= total_in;
         starts_ff    <= starts_in;
         cur_temp_ff  <= cur_temp_in;
         avg_ff       <= avg_in;
         avg_valid_ff <= avg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_if.action;
         s1_temp_ff   <= req_if.temperature;
         s1_switch_ff <= req_if.switch_on;
      end
      if (s1_go) begin
         out_comp_ff    <= comp_in;
         out_fan_ff     <= fan_in;
         out_status_ff  <= status_v;
         out_changed_ff <= changed_v;
         out_avg_ff     <= avg_in;
         out_temp_ff    <= cur_temp_in;
         out_starts_ff  <= starts_in;
         out_runtime_ff <= runtime_v;
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.compressor_on   = out_comp_ff;
   assign rsp_if.fan_on          = out_fan_ff;
   assign rsp_if.status          = out_status_ff;
   assign rsp_if.temp_changed    = out_changed_ff;
   assign rsp_if.average_temp    = out_avg_ff;
   assign rsp_if.latest_temp     = out_temp_ff;
   assign rsp_if.start_count     = out_starts_ff;
   assign rsp_if.runtime_seconds = out_runtime_ff;

endmodule

FILE: hdl/hysteresis_thermostat_compressor_ctrl.sv
`timescale 1ns / 1ps
// An accepted request waits in the input register; its result is loaded into
// the result register once that register is empty or its result is taken.
// Throughput: one request per cycle while results are taken without stall;
// the single update step between input and result register sets that figure.
// Reset (synchronous, active high) empties both registers, turns both relays
// off, clears all counters and loads the register defaults.
module hysteresis_thermostat_compressor_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   htcc_req_if.sink                          req_if,
   htcc_rsp_if.source                        rsp_if,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [htcc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [htcc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [htcc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import htcc_pkg::*;

   cfg_type cfg;

   htcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   htcc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

FILE: hdl/htcc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the thermostat controller, bound to the top level.
// Depends on htcc_pkg and the assertion macros header.
`include "hysteresis_thermostat_compressor_ctrl_defines.svh"

module htcc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_compressor_on,
   input logic [htcc_pkg::STATUS_W-1:0]     rsp_status,
   input logic                              rsp_temp_changed,
   input logic [htcc_pkg::COUNT_W-1:0]      rsp_start_count
);
   import htcc_pkg::*;

   // A stalled result must stay in place.
   `HTCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_start_count), "result dropped or changed while stalled")

   // A refused start leaves the compressor off and is never a sample.
   `HTCC_ASSERT_SAME(a_refused_off, rsp_valid && rsp_status == STATUS_REFUSED, !rsp_compressor_on && !rsp_temp_changed, "refused start with compressor on or sample flag")

   // Only a sample reports a change, and a sample always completes.
   `HTCC_ASSERT_SAME(a_change_done, rsp_valid && rsp_temp_changed, rsp_status == STATUS_DONE, "changed sample reported with non-done status")

   `HTCC_ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid, "result valid right after reset")

endmodule

bind hysteresis_thermostat_compressor_ctrl htcc_checker u_htcc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_compressor_on (rsp_if.compressor_on),
   .rsp_status        (rsp_if.status),
   .rsp_temp_changed  (rsp_if.temp_changed),
   .rsp_start_count   (rsp_if.start_count)
);
